// ===== design/hrsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrsp_pkg;

	// Most results one request byte can cause.
	localparam int MaxRes   = 4;
	localparam int ResIdxW  = $clog2(MaxRes);
	localparam int ResCntW  = $clog2(MaxRes + 1);

	// Result kinds.
	localparam logic [2:0] K_BYTE = 3'd0;
	localparam logic [2:0] K_END  = 3'd1;
	localparam logic [2:0] K_KEPT = 3'd2;
	localparam logic [2:0] K_DROP = 3'd3;
	localparam logic [2:0] K_DONE = 3'd4;
	localparam logic [2:0] K_BAD  = 3'd5;

	// Field tags.
	localparam logic [2:0] TAG_METHOD  = 3'd0;
	localparam logic [2:0] TAG_URL     = 3'd1;
	localparam logic [2:0] TAG_VERSION = 3'd2;
	localparam logic [2:0] TAG_KEY     = 3'd3;
	localparam logic [2:0] TAG_VALUE   = 3'd4;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] field_tag;
		logic [2:0] kind;
		logic       method_is_get;
		logic       last_of_run;
	} result_t;

	// All results of one byte, handed from the parser core to the result queue.
	typedef struct packed {
		logic [ResCntW-1:0]           count;
		result_t [MaxRes-1:0]         res;
	} step_out_t;

endpackage

`default_nettype wire

// ===== design/http_request_stream_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HTTP/1.1 request head parser, one request byte per item.
// Input channel: in_valid/in_ready carry data_byte. Output channel: out_valid/out_ready
// carry one result item (out_byte, field_tag, kind, method_is_get, last_of_run); a byte
// may cause zero to four result items, and last_of_run marks the final one of each byte.
// Configuration: cfg_we writes cfg_wdata into the URL decode enable at once; write it
// only while the parser is idle.
// Flow: an accepted byte is captured in the input register, parsed out of it once four
// queue slots are free, and all its results are written to the queue together; its
// first result then reaches the output from the queue head.
// Throughput: one byte per cycle as long as bytes yield at most one result on average;
// the output drains one result per cycle while out_ready is high, from an eight-entry
// result queue, and a byte is parsed only while the queue has room for four results,
// so bytes that yield several results (line ends, broken escapes) hold the input back.
// Reset: the parser returns to the method phase with no held escape bytes, the queue
// empties and URL decoding is enabled.
// A stalled receiver fills the queue; the input register then holds its byte and
// in_ready drops until space frees up. No item is lost or repeated.
module http_request_stream_parser_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [2:0]      field_tag,
	output logic [2:0]      kind,
	output logic            method_is_get,
	output logic            last_of_run,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata
);
	import hrsp_pkg::*;

	localparam int FifoDepth = 8;
	localparam int PtrW      = $clog2(FifoDepth);
	localparam int CntW      = $clog2(FifoDepth + 1);

	logic              url_decode_enable_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              fire;
	step_out_t         step;
	result_t           fifo_q [FifoDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   cnt_q;
	logic              pop;
	logic [CntW-1:0]   push_n;
	result_t           head;

	// The byte in the input register is parsed only when four queue slots are free.
	assign fire     = valid_s1 && (cnt_q <= CntW'(FifoDepth - MaxRes));
	assign in_ready = !valid_s1 || fire;
	assign pop      = out_valid && out_ready;
	assign push_n   = fire ? CntW'(step.count) : '0;

	hrsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (fire),
		.byte_in   (byte_s1),
		.decode_en (url_decode_enable_q),
		.step_out  (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_decode_enable_q <= 1'b1;
		end else if (cfg_we) begin
			url_decode_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// Result queue: all results of one byte are written in the same cycle.
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MaxRes; i++) begin
				if (ResCntW'(i) < step.count) begin
					fifo_q[wr_ptr_q + PtrW'(i)] <= step.res[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			cnt_q <= cnt_q + push_n - CntW'(pop);
		end
	end

	assign head          = fifo_q[rd_ptr_q];
	assign out_valid     = (cnt_q != '0);
	assign out_byte      = head.out_byte;
	assign field_tag     = head.field_tag;
	assign kind          = head.kind;
	assign method_is_get = head.method_is_get;
	assign last_of_run   = head.last_of_run;

endmodule

`default_nettype wire

// ===== design/hrsp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrsp_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step_en,
	input  wire logic [7:0]          byte_in,
	input  wire logic                decode_en,
	output hrsp_pkg::step_out_t      step_out
);
	import hrsp_pkg::*;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] GetWord [3] = '{8'h67, 8'h65, 8'h74};

	typedef enum logic [2:0] {
		PH_METHOD,
		PH_URL,
		PH_VERSION,
		PH_KEY,
		PH_VALUE,
		PH_VALUE_NOKEY
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] held_bytes;
		logic [1:0]  held_cnt;
		logic        cr_pending;
		logic        colon_pending;
		logic        line_has_bytes;
		logic        field_nonempty;
		logic [2:0]  get_prog;
	} st_t;

	typedef struct packed {
		st_t                  st;
		result_t [MaxRes-1:0] res;
		logic [ResCntW-1:0]   n;
	} ctx_t;

	st_t  st_q;
	st_t  st_d;
	ctx_t c;

	function automatic ctx_t emit(ctx_t ci, logic [7:0] b, logic [2:0] tag, logic [2:0] k,
			logic g);
		ctx_t r;
		r = ci;
		if (r.n != ResCntW'(MaxRes)) begin
			r.res[r.n[ResIdxW-1:0]].out_byte      = b;
			r.res[r.n[ResIdxW-1:0]].field_tag     = tag;
			r.res[r.n[ResIdxW-1:0]].kind          = k;
			r.res[r.n[ResIdxW-1:0]].method_is_get = g;
			r.res[r.n[ResIdxW-1:0]].last_of_run   = 1'b0;
			r.n = r.n + ResCntW'(1);
		end
		return r;
	endfunction

	function automatic ctx_t content(ctx_t ci, logic [7:0] b, logic [2:0] tag);
		ctx_t r;
		r = emit(ci, b, tag, K_BYTE, 1'b0);
		r.st.field_nonempty = 1'b1;
		return r;
	endfunction

	function automatic logic is_hex(logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = b - 8'h30;
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = b - 8'h57;
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = b - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic ctx_t flush_held(ctx_t ci);
		ctx_t r;
		r = ci;
		if (r.st.held_cnt == 2'd1) begin
			r = content(r, r.st.held_bytes[7:0], TAG_URL);
		end else if (r.st.held_cnt >= 2'd2) begin
			r = content(r, r.st.held_bytes[15:8], TAG_URL);
			r = content(r, r.st.held_bytes[7:0], TAG_URL);
		end
		r.st.held_bytes = '0;
		r.st.held_cnt   = '0;
		return r;
	endfunction

	function automatic ctx_t url_fresh(ctx_t ci, logic [7:0] b);
		ctx_t r;
		r = ci;
		if (b == CH_PCT) begin
			r.st.held_bytes = {8'h00, b};
			r.st.held_cnt   = 2'd1;
		end else begin
			r = content(r, b, TAG_URL);
		end
		return r;
	endfunction

	function automatic ctx_t url_byte(ctx_t ci, logic [7:0] b, logic en);
		ctx_t r;
		r = ci;
		priority if (!en) begin
			r = flush_held(r);
			r = content(r, b, TAG_URL);
		end else if (r.st.held_cnt == 2'd0) begin
			r = url_fresh(r, b);
		end else if (r.st.held_cnt == 2'd1 && is_hex(b)) begin
			r.st.held_bytes = {r.st.held_bytes[7:0], b};
			r.st.held_cnt   = 2'd2;
		end else if (r.st.held_cnt >= 2'd2 && is_hex(b)) begin
			r = content(r, {hex_val(r.st.held_bytes[7:0]), hex_val(b)}, TAG_URL);
			r.st.held_bytes = '0;
			r.st.held_cnt   = '0;
		end else begin
			r = flush_held(r);
			r = url_fresh(r, b);
		end
		return r;
	endfunction

	function automatic ctx_t rearm(ctx_t ci);
		ctx_t r;
		r = ci;
		r.st.phase          = PH_METHOD;
		r.st.held_bytes     = '0;
		r.st.held_cnt       = '0;
		r.st.colon_pending  = 1'b0;
		r.st.line_has_bytes = 1'b0;
		r.st.field_nonempty = 1'b0;
		r.st.get_prog       = '0;
		return r;
	endfunction

	function automatic ctx_t next_line(ctx_t ci);
		ctx_t r;
		r = ci;
		r.st.phase          = PH_KEY;
		r.st.line_has_bytes = 1'b0;
		r.st.field_nonempty = 1'b0;
		r.st.colon_pending  = 1'b0;
		return r;
	endfunction

	function automatic ctx_t ordinary(ctx_t ci, logic [7:0] b, logic en);
		ctx_t       r;
		logic       split;
		logic [7:0] lb;
		r = ci;
		split = 1'b0;
		lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
		r.st.line_has_bytes = 1'b1;
		unique case (r.st.phase)
			PH_URL: begin
				if (b == CH_SP) begin
					r = flush_held(r);
					r = emit(r, 8'h00, TAG_URL, K_END, 1'b0);
					r.st.field_nonempty = 1'b0;
					r.st.phase = PH_VERSION;
				end else begin
					r = url_byte(r, b, en);
				end
			end
			PH_VERSION: begin
				r = content(r, b, TAG_VERSION);
			end
			PH_KEY: begin
				if (r.st.colon_pending) begin
					r.st.colon_pending = 1'b0;
					if (b == CH_SP) begin
						r = emit(r, 8'h00, TAG_KEY, K_END, 1'b0);
						r.st.phase = r.st.field_nonempty ? PH_VALUE : PH_VALUE_NOKEY;
						r.st.field_nonempty = 1'b0;
						split = 1'b1;
					end else begin
						r = content(r, CH_COLON, TAG_KEY);
					end
				end
				if (!split) begin
					if (b == CH_COLON) begin
						r.st.colon_pending = 1'b1;
					end else begin
						r = content(r, b, TAG_KEY);
					end
				end
			end
			PH_VALUE, PH_VALUE_NOKEY: begin
				r = content(r, b, TAG_VALUE);
			end
			default: begin
				if (b == CH_SP) begin
					r = emit(r, 8'h00, TAG_METHOD, K_END, r.st.get_prog == 3'd3);
					r.st.field_nonempty = 1'b0;
					r.st.phase = PH_URL;
				end else begin
					if (r.st.get_prog < 3'd3 && lb == GetWord[r.st.get_prog[1:0]]) begin
						r.st.get_prog = r.st.get_prog + 3'd1;
					end else begin
						r.st.get_prog = 3'd4;
					end
					r = content(r, b, TAG_METHOD);
				end
			end
		endcase
		return r;
	endfunction

	function automatic ctx_t line_end(ctx_t ci);
		ctx_t r;
		r = ci;
		unique case (r.st.phase)
			PH_URL: begin
				r = flush_held(r);
				r = emit(r, 8'h00, TAG_URL, K_BAD, 1'b0);
				r = rearm(r);
			end
			PH_VERSION: begin
				r = emit(r, 8'h00, TAG_VERSION, K_END, 1'b0);
				r = next_line(r);
			end
			PH_KEY: begin
				if (!r.st.line_has_bytes) begin
					r = emit(r, 8'h00, TAG_METHOD, K_DONE, 1'b0);
					r = rearm(r);
				end else begin
					r = emit(r, 8'h00, TAG_KEY, K_DROP, 1'b0);
					r = next_line(r);
				end
			end
			PH_VALUE, PH_VALUE_NOKEY: begin
				r = emit(r, 8'h00, TAG_VALUE, K_END, 1'b0);
				r = emit(r, 8'h00, TAG_VALUE,
					(r.st.phase == PH_VALUE && r.st.field_nonempty) ? K_KEPT : K_DROP, 1'b0);
				r = next_line(r);
			end
			default: begin
				// Empty lines ahead of a request are skipped.
				if (r.st.line_has_bytes) begin
					r = emit(r, 8'h00, TAG_METHOD, K_BAD, 1'b0);
					r = rearm(r);
				end
			end
		endcase
		return r;
	endfunction

	always_comb begin
		logic lf_done;
		lf_done = 1'b0;
		c.st  = st_q;
		c.res = '0;
		c.n   = '0;
		if (c.st.cr_pending) begin
			c.st.cr_pending = 1'b0;
			if (byte_in == CH_LF) begin
				c = line_end(c);
				lf_done = 1'b1;
			end else begin
				// A CR without LF is plain content.
				c = ordinary(c, CH_CR, decode_en);
			end
		end
		if (!lf_done) begin
			if (byte_in == CH_CR) begin
				if (c.st.phase == PH_KEY && c.st.colon_pending) begin
					c.st.colon_pending  = 1'b0;
					c.st.line_has_bytes = 1'b1;
					c = content(c, CH_COLON, TAG_KEY);
				end
				c.st.cr_pending = 1'b1;
			end else begin
				c = ordinary(c, byte_in, decode_en);
			end
		end
		if (c.n != '0) begin
			c.res[ResIdxW'(c.n - ResCntW'(1))].last_of_run = 1'b1;
		end
		st_d           = c.st;
		step_out.count = c.n;
		step_out.res   = c.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase          <= PH_METHOD;
			st_q.held_bytes     <= '0;
			st_q.held_cnt       <= '0;
			st_q.cr_pending     <= 1'b0;
			st_q.colon_pending  <= 1'b0;
			st_q.line_has_bytes <= 1'b0;
			st_q.field_nonempty <= 1'b0;
			st_q.get_prog       <= '0;
		end else if (step_en) begin
			st_q <= st_d;
		end
	end

endmodule

`default_nettype wire
